/* src/sips_pkg.sv */
// sips_pkg: shared types and constants for the sorted insert position search.
// Used by sorted_insert_position_search; no dependencies.

package sips_pkg;

	localparam int ValueW        = 32;
	localparam int IndexW        = 10;
	localparam int CountW        = 11;
	localparam int PosW          = 11;
	localparam int AddrW         = 3;
	localparam int DataW         = 32;
	localparam int DefTableDepth = 1024;

	localparam logic [AddrW-1:0] REG_ENTRY_COUNT = 3'd0;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP
	} state_t;

endpackage

/* src/sips_ram.sv */
// sips_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.

module sips_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/sorted_insert_position_search.sv */
// sorted_insert_position_search: binary search over a sorted table held in RAM.
// Depends on sips_pkg and sips_ram.
//
// channel   direction  signals                          handshake
// command   in         mode, index, value               start & !busy
// result    out        position                         done, one cycle
// config    in/out     psel penable pwrite paddr pwdata prdata pready  APB
//
// A write to an index inside the table goes to the RAM when accepted. Each search
// probe is a RAM read (ST_READ), then a compare (ST_CMP); the search ends in ST_CMP
// on a match or in ST_READ once the range is empty, P <= ceil(log2(n+1)) probes.
// Reset clears the controller and entry_count; table contents are undefined
// until written. The receiver cannot stall: position is valid while done is high.

module sorted_insert_position_search #(
	parameter int TABLE_DEPTH = sips_pkg::DefTableDepth
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              mode,
	input  logic [sips_pkg::IndexW-1:0]       index,
	input  logic signed [sips_pkg::ValueW-1:0] value,
	output logic                              done,
	output logic [sips_pkg::PosW-1:0]         position,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sips_pkg::AddrW-1:0]        paddr,
	input  logic [sips_pkg::DataW-1:0]        pwdata,
	output logic [sips_pkg::DataW-1:0]        prdata,
	output logic                              pready
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = sips_pkg::CountW;

	sips_pkg::state_t state_q, state_d;

	logic [CW-1:0]                    entry_count_q;
	logic [CW-1:0]                    low_q, low_d;
	logic [CW-1:0]                    hix_q, hix_d;   // exclusive upper bound
	logic [CW-1:0]                    mid_q, mid_d;
	logic signed [sips_pkg::ValueW-1:0] target_q, target_d;
	logic                             done_q, done_d;
	logic [sips_pkg::PosW-1:0]        position_q, position_d;

	logic [CW-1:0]                    eff_count;
	logic [CW-1:0]                    span;
	logic [CW-1:0]                    mid_c;
	logic                             accept;
	logic                             ram_we;
	logic                             ram_re;
	logic signed [sips_pkg::ValueW-1:0] ram_rdata;

	assign accept = start && (state_q == sips_pkg::ST_IDLE);
	assign busy   = (state_q != sips_pkg::ST_IDLE);
	assign pready = 1'b1;

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (psel && penable && pwrite && paddr == sips_pkg::REG_ENTRY_COUNT) begin
			entry_count_q <= pwdata[CW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == sips_pkg::REG_ENTRY_COUNT) begin
			prdata = {{(sips_pkg::DataW-CW){1'b0}}, entry_count_q};
		end
	end

	assign eff_count = ({{(32-CW){1'b0}}, entry_count_q} > 32'(TABLE_DEPTH))
		? CW'(TABLE_DEPTH) : entry_count_q;

	assign span  = hix_q - low_q - 1'b1;
	assign mid_c = low_q + (span >> 1);

	assign ram_we = accept && (mode == sips_pkg::MODE_WRITE)
		&& ({{(32-sips_pkg::IndexW){1'b0}}, index} < 32'(TABLE_DEPTH));
	assign ram_re = (state_q == sips_pkg::ST_READ) && (low_q < hix_q);

	sips_ram #(
		.WIDTH(sips_pkg::ValueW),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(index)),
		.wdata(value),
		.re   (ram_re),
		.raddr(AW'(mid_c)),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sips_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		low_q      <= low_d;
		hix_q      <= hix_d;
		mid_q      <= mid_d;
		target_q   <= target_d;
		position_q <= position_d;
	end

	always_comb begin
		state_d    = state_q;
		low_d      = low_q;
		hix_d      = hix_q;
		mid_d      = mid_q;
		target_d   = target_q;
		done_d     = 1'b0;
		position_d = position_q;
		case (state_q)
			sips_pkg::ST_IDLE: begin
				if (accept && mode == sips_pkg::MODE_SEARCH) begin
					low_d    = '0;
					hix_d    = eff_count;
					target_d = value;
					state_d  = sips_pkg::ST_READ;
				end
			end
			sips_pkg::ST_READ: begin
				if (low_q < hix_q) begin
					mid_d   = mid_c;
					state_d = sips_pkg::ST_CMP;
				end else begin
					done_d     = 1'b1;
					position_d = low_q;
					state_d    = sips_pkg::ST_IDLE;
				end
			end
			sips_pkg::ST_CMP: begin
				if (ram_rdata == target_q) begin
					done_d     = 1'b1;
					position_d = mid_q;
					state_d    = sips_pkg::ST_IDLE;
				end else if (ram_rdata < target_q) begin
					low_d   = mid_q + 1'b1;
					state_d = sips_pkg::ST_READ;
				end else begin
					hix_d   = mid_q;
					state_d = sips_pkg::ST_READ;
				end
			end
			default: begin
				state_d = sips_pkg::ST_IDLE;
			end
		endcase
	end

	assign done     = done_q;
	assign position = position_q;

endmodule
